FILE: hdl/spmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spmq_pkg;

	localparam int DEFAULT_CAPACITY = 16;
	localparam int DATA_W = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W = 5;

	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_DEQUEUE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic action;
		logic signed [DATA_W-1:0] entry_value;
		logic signed [DATA_W-1:0] entry_priority;
	} req_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic signed [DATA_W-1:0] removed_value;
		logic signed [DATA_W-1:0] removed_priority;
		logic [OCC_W-1:0] occupancy;
	} rsp_item_t;

	// One held entry of the sorted row.
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} slot_t;

	// Command broadcast to every cell of the row in the same cycle.
	typedef struct packed {
		logic enq;
		logic deq;
		slot_t incoming;
	} cell_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/spmq_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface spmq_req_if;
	import spmq_pkg::*;
	logic valid;
	logic ready;
	req_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spmq_rsp_if;
	import spmq_pkg::*;
	logic valid;
	logic ready;
	rsp_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/spmq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module spmq_cell (
	input wire logic clk,
	input wire spmq_pkg::cell_ctl_t ctl,
	input wire logic held,
	input wire spmq_pkg::slot_t left_slot,
	input wire logic left_moves,
	input wire spmq_pkg::slot_t right_slot,
	output spmq_pkg::slot_t slot,
	output logic moves
);
	import spmq_pkg::*;

	slot_t slot_q;

	// An empty cell, or one whose priority is strictly larger than the new key,
	// lies at or behind the insertion point and moves one place back.
	assign moves = !held || (slot_q.prio > ctl.incoming.prio);
	assign slot = slot_q;

	always_ff @(posedge clk) begin
		if (ctl.enq && moves) begin
			slot_q <= left_moves ? left_slot : ctl.incoming;
		end else if (ctl.deq) begin
			slot_q <= right_slot;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/stable_min_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Bounded priority queue held as a sorted row of CAPACITY cells, head in cell
// zero. Each item is an enqueue or a dequeue and gets one result. An enqueue
// lands behind all entries of equal or smaller priority, so equal priorities
// leave in arrival order; a full queue drops it with status 2. A dequeue of an
// empty queue returns status 1. Every cell compares its priority with the new
// key and shifts in parallel, so an item is finished in the cycle it is
// accepted: one item per clock unless rsp stalls, with the result in an
// output register next cycle. Occupancy gives the held count in five bits.
module stable_min_priority_queue #(
	parameter int CAPACITY = spmq_pkg::DEFAULT_CAPACITY
) (
	input wire logic clk,
	input wire logic arst_n,
	spmq_req_if.sink req,
	spmq_rsp_if.source rsp
);
	import spmq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [CNT_W+OCC_W-1:0] occ_wide;
	logic rsp_valid_q;
	rsp_item_t rsp_q;
	logic accept;
	logic is_full;
	logic is_empty;
	cell_ctl_t ctl;
	rsp_item_t result;

	slot_t slots [CAPACITY];
	logic moves [CAPACITY];
	logic held [CAPACITY];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;
	assign is_full = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	assign ctl.enq = accept && (req.data.action == ACT_ENQUEUE) && !is_full;
	assign ctl.deq = accept && (req.data.action == ACT_DEQUEUE) && !is_empty;
	assign ctl.incoming.value = req.data.entry_value;
	assign ctl.incoming.prio = req.data.entry_priority;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		slot_t left_slot;
		slot_t right_slot;
		logic left_moves;

		assign held[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_slot = ctl.incoming;
			assign left_moves = 1'b0;
		end else begin : g_body
			assign left_slot = slots[i-1];
			assign left_moves = moves[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_slot = slots[i];
		end else begin : g_inner
			assign right_slot = slots[i+1];
		end

		spmq_cell u_cell (
			.clk(clk),
			.ctl(ctl),
			.held(held[i]),
			.left_slot(left_slot),
			.left_moves(left_moves),
			.right_slot(right_slot),
			.slot(slots[i]),
			.moves(moves[i])
		);
	end

	always_comb begin
		count_nxt = count_q;
		if (ctl.enq) begin
			count_nxt = count_q + 1'b1;
		end else if (ctl.deq) begin
			count_nxt = count_q - 1'b1;
		end
	end

	assign occ_wide = (CNT_W + OCC_W)'(count_nxt);

	always_comb begin
		result.status = ST_OK;
		result.removed_value = '0;
		result.removed_priority = '0;
		result.occupancy = occ_wide[OCC_W-1:0];
		if (req.data.action == ACT_ENQUEUE) begin
			if (is_full) begin
				result.status = ST_FULL;
			end
		end else if (is_empty) begin
			result.status = ST_EMPTY;
		end else begin
			result.removed_value = slots[0].value;
			result.removed_priority = slots[0].prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

endmodule
`default_nettype wire
